FILE: rtl/lfss_pkg.sv
// Package with types, constants and helper functions for the line follower steering and speed unit.
`timescale 1ns / 1ps

package lfss_pkg;

    // Sensor row and field widths.
    localparam int unsigned SENSOR_COUNT = 8;
    localparam int unsigned LIT_W        = 4;
    localparam int unsigned DIR_W        = 8;
    localparam int unsigned STEER_W      = 14;
    localparam int unsigned SPEED_W      = 10;
    localparam int unsigned LAPS_W       = 3;
    localparam int unsigned TACHO_W      = 16;
    localparam int unsigned CFG_DATA_W   = 14;
    localparam int unsigned CFG_INDEX_W  = 3;

    // Fixed constants of the steering and speed law.
    localparam logic [LAPS_W-1:0]         LAPS_MAX       = 3'd7;
    localparam logic signed [STEER_W-1:0] STEER_GAIN     = 14'sd45;
    localparam logic [6:0]                DIR_FULL       = 7'd100;
    localparam logic signed [DIR_W-1:0]   DIR_HARD       = 8'sd100;
    localparam logic signed [DIR_W-1:0]   DIR_MID        = 8'sd70;
    localparam logic signed [DIR_W-1:0]   DIR_SOFT       = 8'sd35;
    localparam logic [SPEED_W-1:0]        SPEED_RESET    = 10'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CROSSING_THRESHOLD = 3'd0,
        REG_LAP_LIMIT          = 3'd1,
        REG_SPEED_STEP         = 3'd2,
        REG_SPEED_MAX          = 3'd3,
        REG_BASE_RATE          = 3'd4,
        REG_RATE_SPAN_PER_UNIT = 3'd5
    } lfss_reg_e_t;

    // Input item carried by one transfer on the s_ channel.
    typedef struct packed {
        logic [SENSOR_COUNT-1:0] line_bits;
        logic                    start_pressed;
        logic [TACHO_W-1:0]      tacho_rate;
    } lfss_in_t;

    // Result item carried by one transfer on the m_ channel.
    typedef struct packed {
        logic signed [STEER_W-1:0] steer_angle;
        logic [SPEED_W-1:0]        motor_speed;
        logic [LAPS_W-1:0]         lap_count;
        logic                      is_driving;
        logic                      run_ended;
    } lfss_out_t;

    // Configuration register set.
    typedef struct packed {
        logic [3:0]  crossing_threshold;
        logic [2:0]  lap_limit;
        logic [6:0]  speed_step;
        logic [9:0]  speed_max;
        logic [13:0] base_rate;
        logic [6:0]  rate_span_per_unit;
    } lfss_cfg_t;

    // Run state carried from one sample to the next.
    typedef struct packed {
        logic signed [DIR_W-1:0] held_direction;
        logic                    on_crossing;
        logic [LAPS_W-1:0]       laps;
        logic                    driving;
        logic [SPEED_W-1:0]      speed_level;
        logic [SPEED_W-1:0]      motor_level;
    } lfss_state_t;

    // Priority encode of the lit sensors; outer sensors win over inner ones.
    function automatic logic signed [DIR_W-1:0] encode_direction(
        input logic [SENSOR_COUNT-1:0] bits,
        input logic signed [DIR_W-1:0] fallback
    );
        logic signed [DIR_W-1:0] dir;
        if (bits[0]) begin
            dir = DIR_HARD;
        end else if (bits[7]) begin
            dir = -DIR_HARD;
        end else if (bits[1]) begin
            dir = DIR_MID;
        end else if (bits[6]) begin
            dir = -DIR_MID;
        end else if (bits[2]) begin
            dir = DIR_SOFT;
        end else if (bits[5]) begin
            dir = -DIR_SOFT;
        end else if (bits[3] || bits[4]) begin
            dir = '0;
        end else begin
            dir = fallback;
        end
        return dir;
    endfunction

endpackage

FILE: rtl/lfss_eval.sv
// Combinational evaluation of one sensor sample against the current run state.
`timescale 1ns / 1ps

module lfss_eval (
    input  lfss_pkg::lfss_cfg_t   cfg,
    input  lfss_pkg::lfss_state_t state_cur,
    input  lfss_pkg::lfss_in_t    item,
    output lfss_pkg::lfss_state_t state_next,
    output lfss_pkg::lfss_out_t   result
);

    logic                                   driving;
    logic [lfss_pkg::LIT_W-1:0]             lit;
    logic                                   crossing;
    logic [lfss_pkg::LAPS_W-1:0]            laps;
    logic signed [lfss_pkg::DIR_W-1:0]      dir;
    logic [6:0]                             mag;
    logic [6:0]                             straight;
    logic [13:0]                            span;
    logic [16:0]                            desired;
    logic signed [11:0]                     speed_sum;
    logic [lfss_pkg::SPEED_W-1:0]           speed_new;

    always_comb begin
        // A start request takes effect before the sample is evaluated.
        driving = state_cur.driving | item.start_pressed;

        // Count the lit sensors.
        lit = '0;
        for (int k = 0; k < lfss_pkg::SENSOR_COUNT; k++) begin
            lit = lit + lfss_pkg::LIT_W'(item.line_bits[k]);
        end
        crossing = lit > cfg.crossing_threshold;

        // Lap counting on the first sample of a crossing, saturating at the top.
        laps = state_cur.laps;
        if (crossing && !state_cur.on_crossing && state_cur.laps != lfss_pkg::LAPS_MAX) begin
            laps = state_cur.laps + 3'd1;
        end

        // Direction: zero on a crossing, otherwise the encode with the held fallback.
        if (crossing) begin
            dir = '0;
        end else begin
            dir = lfss_pkg::encode_direction(item.line_bits, state_cur.held_direction);
        end

        // Desired rate grows with straightness.
        mag      = dir[lfss_pkg::DIR_W-1] ? 7'(-dir) : 7'(dir);
        straight = lfss_pkg::DIR_FULL - mag;
        span     = 14'(straight) * 14'(cfg.rate_span_per_unit);
        desired  = 17'(cfg.base_rate) + 17'(span);

        // Step the speed toward the desired rate and saturate to 0..speed_max.
        if (desired >= 17'(item.tacho_rate)) begin
            speed_sum = $signed({2'b00, state_cur.speed_level}) + $signed({5'b0, cfg.speed_step});
        end else begin
            speed_sum = $signed({2'b00, state_cur.speed_level}) - $signed({5'b0, cfg.speed_step});
        end
        if (speed_sum > $signed({2'b00, cfg.speed_max})) begin
            speed_new = cfg.speed_max;
        end else if (speed_sum < 12'sd0) begin
            speed_new = '0;
        end else begin
            speed_new = speed_sum[lfss_pkg::SPEED_W-1:0];
        end

        // Defaults: run continues.
        state_next.held_direction = dir;
        state_next.on_crossing    = crossing;
        state_next.laps           = laps;
        state_next.driving        = driving;
        state_next.speed_level    = state_cur.speed_level;
        state_next.motor_level    = state_cur.motor_level;
        result.steer_angle        = 14'(dir) * lfss_pkg::STEER_GAIN;
        result.run_ended          = 1'b0;

        if (laps > cfg.lap_limit) begin
            // The lap limit is exceeded: stop the motor and end the run.
            state_next.motor_level = '0;
            state_next.driving     = 1'b0;
            state_next.laps        = '0;
            result.steer_angle     = '0;
            result.run_ended       = 1'b1;
        end else if (driving) begin
            state_next.speed_level = speed_new;
            state_next.motor_level = speed_new;
        end

        result.motor_speed = state_next.motor_level;
        result.lap_count   = state_next.laps;
        result.is_driving  = state_next.driving;
    end

endmodule

FILE: rtl/line_follower_steer_speed_unit.sv
// Top level of the line follower steering and speed unit.
`timescale 1ns / 1ps

// The unit takes one sensor sample per cycle while m_ready keeps the result
// register draining, and returns one result per sample, in order. A sample is
// first captured in an input register; when the result register is free or being
// emptied, the evaluation logic reads it together with the run state, updates the
// state and loads the result register, whose valid flag drives m_valid. The state
// loop (laps, direction, speed) closes through the evaluation logic and the state
// register, so each sample sees the state left by the one before it. A stalled
// m_ready holds the result register and then the input register; the configuration
// registers are written through cfg_we, cfg_index and cfg_data and should only
// change while the unit is idle.
module line_follower_steer_speed_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  lfss_pkg::lfss_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output lfss_pkg::lfss_out_t                   m_data,
    input  logic                                  cfg_we,
    input  logic [lfss_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lfss_pkg::CFG_DATA_W-1:0]       cfg_data
);

    lfss_pkg::lfss_cfg_t   cfg_reg;
    lfss_pkg::lfss_state_t state_reg;
    lfss_pkg::lfss_state_t state_next;
    lfss_pkg::lfss_in_t    in_data_reg;
    logic                  in_valid_reg;
    lfss_pkg::lfss_out_t   out_data_reg;
    lfss_pkg::lfss_out_t   out_data_next;
    logic                  out_valid_reg;
    logic                  advance;

    // The held sample moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crossing_threshold <= 4'd3;
            cfg_reg.lap_limit          <= 3'd3;
            cfg_reg.speed_step         <= 7'd3;
            cfg_reg.speed_max          <= 10'd800;
            cfg_reg.base_rate          <= 14'd900;
            cfg_reg.rate_span_per_unit <= 7'd5;
        end else if (cfg_we) begin
            case (lfss_pkg::lfss_reg_e_t'(cfg_index))
                lfss_pkg::REG_CROSSING_THRESHOLD: cfg_reg.crossing_threshold <= cfg_data[3:0];
                lfss_pkg::REG_LAP_LIMIT:          cfg_reg.lap_limit          <= cfg_data[2:0];
                lfss_pkg::REG_SPEED_STEP:         cfg_reg.speed_step         <= cfg_data[6:0];
                lfss_pkg::REG_SPEED_MAX:          cfg_reg.speed_max          <= cfg_data[9:0];
                lfss_pkg::REG_BASE_RATE:          cfg_reg.base_rate          <= cfg_data[13:0];
                lfss_pkg::REG_RATE_SPAN_PER_UNIT: cfg_reg.rate_span_per_unit <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Input register: captures a sample on each s_ transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // Sample evaluation.
    lfss_eval u_eval (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (out_data_next)
    );

    // Run state follows each evaluated sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.held_direction <= '0;
            state_reg.on_crossing    <= 1'b0;
            state_reg.laps           <= '0;
            state_reg.driving        <= 1'b0;
            state_reg.speed_level    <= lfss_pkg::SPEED_RESET;
            state_reg.motor_level    <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register toward the m_ channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
